// ===== src/rcfp_pkg.sv =====
// Shared types, constants and register codes of the channel frame parser.
package rcfp_pkg;

   // Widths fixed by the frame format.
   localparam int BYTE_W  = 8;
   localparam int VALUE_W = 16;
   localparam int SLOT_W  = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Default channel count and reset values of the configuration registers.
   localparam int DEFAULT_CHANNELS = 4;
   localparam logic [BYTE_W-1:0]         TIMEOUT_RESET    = 8'd100;
   localparam logic signed [VALUE_W-1:0] LIMIT_HIGH_RESET = 16'sd500;
   localparam logic signed [VALUE_W-1:0] LIMIT_LOW_RESET  = -16'sd500;

   // Sync mark bytes and counter landmarks.
   localparam logic [BYTE_W-1:0] SYNC_OUTER = 8'h00;
   localparam logic [BYTE_W-1:0] SYNC_INNER = 8'hFF;
   localparam logic [BYTE_W-1:0] COUNT_MAX  = 8'hFF;
   localparam logic [BYTE_W-1:0] GROUP_LEN  = 8'd3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_LOW  = 2'd2;

   // Configuration seen by the update logic.
   typedef struct packed {
      logic [BYTE_W-1:0]         timeout_bytes;
      logic signed [VALUE_W-1:0] limit_high;
      logic signed [VALUE_W-1:0] limit_low;
   } cfg_type;

   // Parser control state.
   typedef struct packed {
      logic [BYTE_W-1:0] win0;
      logic [BYTE_W-1:0] win1;
      logic [BYTE_W-1:0] win2;
      logic [BYTE_W-1:0] count;
      logic [SLOT_W-1:0] slot;
      logic              error;
   } parse_state_type;

endpackage

// ===== src/rcfp_step.sv =====
// Next-state logic of the parser for one received byte.
module rcfp_step #(
   parameter int CHANNELS = rcfp_pkg::DEFAULT_CHANNELS
) (
   input  rcfp_pkg::cfg_type                          cfg,
   input  rcfp_pkg::parse_state_type                  state_cur,
   input  logic signed [rcfp_pkg::VALUE_W-1:0]        chan_cur [CHANNELS],
   input  logic [rcfp_pkg::BYTE_W-1:0]                rx_byte,
   output rcfp_pkg::parse_state_type                  state_nxt,
   output logic signed [rcfp_pkg::VALUE_W-1:0]        chan_nxt [CHANNELS]
);

   logic [rcfp_pkg::BYTE_W-1:0]         w0, w1, w2;
   logic [rcfp_pkg::BYTE_W-1:0]         cnt_inc, cnt_held;
   logic                                timeout_hit, sync_seen, group_due, check_ok;
   logic                                in_range, slot_free, store_en;
   logic signed [rcfp_pkg::VALUE_W-1:0] raw_value;

   // Shift the window and advance the saturating byte counter.
   assign w0 = state_cur.win1;
   assign w1 = state_cur.win2;
   assign w2 = rx_byte;
   assign cnt_inc = (state_cur.count == rcfp_pkg::COUNT_MAX) ? state_cur.count
                                                             : state_cur.count + 8'd1;

   // Timeout holds the counter at the limit and clears the channels.
   assign timeout_hit = (cnt_inc > rcfp_pkg::GROUP_LEN) && (cnt_inc >= cfg.timeout_bytes);
   assign cnt_held    = timeout_hit ? cfg.timeout_bytes : cnt_inc;

   // Frame decoding: sync mark first, otherwise a complete group.
   assign sync_seen = (w0 == rcfp_pkg::SYNC_OUTER) && (w1 == rcfp_pkg::SYNC_INNER) &&
                      (w2 == rcfp_pkg::SYNC_OUTER);
   assign group_due = !sync_seen && (cnt_held == rcfp_pkg::GROUP_LEN);
   assign check_ok  = ((w0 ^ w1) == w2);
   assign raw_value = {w1, w0};
   assign in_range  = (raw_value <= cfg.limit_high) && (raw_value >= cfg.limit_low);
   assign slot_free = (state_cur.slot < rcfp_pkg::SLOT_W'(CHANNELS));
   assign store_en  = group_due && check_ok && in_range && slot_free;

   // Channel store: a store into the current slot wins over clearing on a timeout.
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         if (store_en && (state_cur.slot == rcfp_pkg::SLOT_W'(i))) begin
            chan_nxt[i] = raw_value;
         end else if (timeout_hit) begin
            chan_nxt[i] = '0;
         end else begin
            chan_nxt[i] = chan_cur[i];
         end
      end
   end

   // Counter, slot and error flag.
   always_comb begin
      state_nxt      = state_cur;
      state_nxt.win0 = w0;
      state_nxt.win1 = w1;
      state_nxt.win2 = w2;
      state_nxt.count = cnt_held;
      if (sync_seen) begin
         state_nxt.count = '0;
         state_nxt.slot  = '0;
         state_nxt.error = 1'b0;
      end else if (group_due) begin
         if (check_ok) begin
            state_nxt.count = '0;
            state_nxt.error = 1'b0;
            if (slot_free) begin
               state_nxt.slot = state_cur.slot + 3'd1;
            end
         end else begin
            state_nxt.error = 1'b1;
         end
      end
   end

endmodule

// ===== src/rc_channel_frame_parser_core.sv =====
// Top level of the channel frame parser: registers, configuration and handshakes.
//
//   Channel  Direction  Signals                                   Transfer when
//   req      in         req_valid, req_ready, req_rx_byte          valid && ready
//   rsp      out        rsp_valid, rsp_ready, rsp_channel_a..d,    valid && ready
//                       rsp_check_error
//   csr      in         csr_write_enable, csr_index, csr_write_data write enable high
//
// Each byte is taken at its transfer: the state registers are updated there and hold the
// result, from the next cycle on, until the result is taken.
// A new byte is accepted every cycle while the result slot is empty or being emptied.
// Synchronous reset clears all state, the channels and the registers to defaults.
// A stalled result holds the input back; nothing is lost or repeated.
module rc_channel_frame_parser_core #(
   parameter int CHANNELS = rcfp_pkg::DEFAULT_CHANNELS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [rcfp_pkg::BYTE_W-1:0]            req_rx_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [rcfp_pkg::VALUE_W-1:0]    rsp_channel_a,
   output logic signed [rcfp_pkg::VALUE_W-1:0]    rsp_channel_b,
   output logic signed [rcfp_pkg::VALUE_W-1:0]    rsp_channel_c,
   output logic signed [rcfp_pkg::VALUE_W-1:0]    rsp_channel_d,
   output logic                                   rsp_check_error,
   input  logic                                   csr_write_enable,
   input  logic [rcfp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [rcfp_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   rcfp_pkg::cfg_type                   cfg_ff;
   rcfp_pkg::parse_state_type           state_ff, state_in;
   logic signed [rcfp_pkg::VALUE_W-1:0] chan_ff [CHANNELS];
   logic signed [rcfp_pkg::VALUE_W-1:0] chan_in [CHANNELS];
   logic                                rsp_valid_ff;
   logic                                req_fire;

   // Handshake: the state registers double as the result register.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_bytes <= rcfp_pkg::TIMEOUT_RESET;
         cfg_ff.limit_high    <= rcfp_pkg::LIMIT_HIGH_RESET;
         cfg_ff.limit_low     <= rcfp_pkg::LIMIT_LOW_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rcfp_pkg::CSR_TIMEOUT: begin
               cfg_ff.timeout_bytes <= csr_write_data[rcfp_pkg::BYTE_W-1:0];
            end
            rcfp_pkg::CSR_LIMIT_HIGH: begin
               cfg_ff.limit_high <= csr_write_data;
            end
            rcfp_pkg::CSR_LIMIT_LOW: begin
               cfg_ff.limit_low <= csr_write_data;
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Byte update logic.
   rcfp_step #(
      .CHANNELS (CHANNELS)
   ) u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .chan_cur  (chan_ff),
      .rx_byte   (req_rx_byte),
      .state_nxt (state_in),
      .chan_nxt  (chan_in)
   );

   // Parser state, channel store and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            chan_ff[i] <= '0;
         end
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
            for (int i = 0; i < CHANNELS; i++) begin
               chan_ff[i] <= chan_in[i];
            end
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result fields; channels beyond the configured count read zero.
   assign rsp_channel_a   = chan_ff[0];
   assign rsp_channel_b   = chan_ff[1];
   assign rsp_check_error = state_ff.error;

   generate
      if (CHANNELS > 2) begin : g_chan_c
         assign rsp_channel_c = chan_ff[2];
      end else begin : g_no_chan_c
         assign rsp_channel_c = '0;
      end
      if (CHANNELS > 3) begin : g_chan_d
         assign rsp_channel_d = chan_ff[3];
      end else begin : g_no_chan_d
         assign rsp_channel_d = '0;
      end
   endgenerate

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench of the channel frame parser core, with driver, monitor and predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHANNELS       = rcfp_pkg::DEFAULT_CHANNELS;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int STREAM_BYTES   = 115;

   // One snapshot of the channel outputs and the error flag.
   typedef struct packed {
      logic signed [rcfp_pkg::VALUE_W-1:0] channel_a;
      logic signed [rcfp_pkg::VALUE_W-1:0] channel_b;
      logic signed [rcfp_pkg::VALUE_W-1:0] channel_c;
      logic signed [rcfp_pkg::VALUE_W-1:0] channel_d;
      logic                                check_error;
   } frame_snapshot_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [rcfp_pkg::BYTE_W-1:0]         req_rx_byte = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [rcfp_pkg::VALUE_W-1:0] rsp_channel_a;
   logic signed [rcfp_pkg::VALUE_W-1:0] rsp_channel_b;
   logic signed [rcfp_pkg::VALUE_W-1:0] rsp_channel_c;
   logic signed [rcfp_pkg::VALUE_W-1:0] rsp_channel_d;
   logic                                rsp_check_error;
   logic                                csr_write_enable = 1'b0;
   logic [rcfp_pkg::CSR_INDEX_W-1:0]    csr_index = '0;
   logic [rcfp_pkg::CSR_DATA_W-1:0]     csr_write_data = '0;

   // Predictor state and its copy of the registers.
   logic [rcfp_pkg::BYTE_W-1:0]         window [0:2];
   logic [rcfp_pkg::BYTE_W-1:0]         since_mark;
   logic [rcfp_pkg::SLOT_W-1:0]         slot;
   logic [rcfp_pkg::VALUE_W-1:0]        held [0:3];
   logic                                fault;
   logic [rcfp_pkg::BYTE_W-1:0]         cfg_timeout;
   logic signed [rcfp_pkg::VALUE_W-1:0] cfg_ceiling;
   logic signed [rcfp_pkg::VALUE_W-1:0] cfg_floor;

   // Bytes waiting to be offered and snapshots waiting to be seen.
   logic [rcfp_pkg::BYTE_W-1:0] byte_backlog [$];
   frame_snapshot_type          snapshot_due [$];

   int items_queued   = 0;
   int req_taken      = 0;
   int rsp_taken      = 0;
   int mismatches     = 0;
   int settings_count = 0;
   int src_idle_max   = 0;
   int sink_idle_max  = 0;
   int hold_token     = 0;

   rc_channel_frame_parser_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_channel_a    (rsp_channel_a),
      .rsp_channel_b    (rsp_channel_b),
      .rsp_channel_c    (rsp_channel_c),
      .rsp_channel_d    (rsp_channel_d),
      .rsp_check_error  (rsp_check_error),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Returns the stored value of a channel, or zero where the channel is not built.
   function automatic logic signed [rcfp_pkg::VALUE_W-1:0] visible_channel(input int idx);
      return (idx < CHANNELS) ? held[idx[1:0]] : '0;
   endfunction

   // Applies one received byte to the predicted parser state.
   task automatic parse_byte(input logic [rcfp_pkg::BYTE_W-1:0] rx,
                             output frame_snapshot_type snap);
      logic signed [rcfp_pkg::VALUE_W-1:0] raw;
      window[0] = window[1];
      window[1] = window[2];
      window[2] = rx;
      if (since_mark != rcfp_pkg::COUNT_MAX) since_mark++;

      // The timeout only acts once the counter is past one group length.
      if (since_mark > rcfp_pkg::GROUP_LEN && since_mark >= cfg_timeout) begin
         since_mark = cfg_timeout;
         for (int i = 0; i < 4; i++) held[i] = '0;
      end

      if (window[0] == rcfp_pkg::SYNC_OUTER && window[1] == rcfp_pkg::SYNC_INNER &&
          window[2] == rcfp_pkg::SYNC_OUTER) begin
         since_mark = '0;
         slot = '0;
         fault = 1'b0;
      end else if (since_mark == rcfp_pkg::GROUP_LEN) begin
         if ((window[0] ^ window[1]) == window[2]) begin
            raw = {window[1], window[0]};
            if (raw <= cfg_ceiling && raw >= cfg_floor && slot < CHANNELS) begin
               held[slot[1:0]] = raw;
            end
            if (slot < CHANNELS) slot++;
            since_mark = '0;
            fault = 1'b0;
         end else begin
            fault = 1'b1;
         end
      end

      snap.channel_a   = visible_channel(0);
      snap.channel_b   = visible_channel(1);
      snap.channel_c   = visible_channel(2);
      snap.channel_d   = visible_channel(3);
      snap.check_error = fault;
   endtask

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", field, want, got);
         mismatches++;
      end
   endtask

   // Monitor: register writes, result checks and predictions, all at the rising edge.
   always @(posedge clock) begin
      frame_snapshot_type want;
      frame_snapshot_type next;
      if (reset) begin
         for (int i = 0; i < 3; i++) window[i] = '0;
         for (int i = 0; i < 4; i++) held[i] = '0;
         since_mark  = '0;
         slot        = '0;
         fault       = 1'b0;
         cfg_timeout = rcfp_pkg::TIMEOUT_RESET;
         cfg_ceiling = rcfp_pkg::LIMIT_HIGH_RESET;
         cfg_floor   = rcfp_pkg::LIMIT_LOW_RESET;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               rcfp_pkg::CSR_TIMEOUT:    cfg_timeout = csr_write_data[rcfp_pkg::BYTE_W-1:0];
               rcfp_pkg::CSR_LIMIT_HIGH: cfg_ceiling = csr_write_data;
               rcfp_pkg::CSR_LIMIT_LOW:  cfg_floor   = csr_write_data;
               default: ;
            endcase
         end
         // A result transfer belongs to an earlier byte, so it is checked first.
         if (rsp_valid && rsp_ready) begin
            rsp_taken++;
            if (snapshot_due.size() == 0) begin
               $error("result transfer with no prediction waiting");
               mismatches++;
            end else begin
               want = snapshot_due.pop_front();
               compare_field("channel_a", want.channel_a, rsp_channel_a);
               compare_field("channel_b", want.channel_b, rsp_channel_b);
               compare_field("channel_c", want.channel_c, rsp_channel_c);
               compare_field("channel_d", want.channel_d, rsp_channel_d);
               compare_field("check_error", want.check_error, rsp_check_error);
            end
         end
         if (req_valid && req_ready) begin
            parse_byte(req_rx_byte, next);
            snapshot_due.push_back(next);
            req_taken++;
         end
      end
   end

   // Driver: offers the backlog one byte at a time with a random gap after each transfer.
   int  req_seen = 0;
   int  src_wait = 0;
   bit  offering = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_taken != req_seen) begin
            req_seen = req_taken;
            offering = 1'b0;
            src_wait = $urandom_range(0, src_idle_max);
         end
         if (!offering) begin
            if (src_wait > 0) begin
               src_wait--;
               req_valid <= 1'b0;
            end else if (byte_backlog.size() != 0) begin
               req_rx_byte <= byte_backlog.pop_front();
               req_valid   <= 1'b1;
               offering = 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls after each transfer, plus one long hold on request.
   int rsp_seen  = 0;
   int sink_wait = 0;
   int hold_seen = 0;
   int hold_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_taken != rsp_seen) begin
            rsp_seen  = rsp_taken;
            sink_wait = $urandom_range(0, sink_idle_max);
         end
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (sink_wait > 0) begin
            sink_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run if no transfer of any kind happens for too long.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timed out after %0d cycles without a transfer.", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic push_byte(input logic [rcfp_pkg::BYTE_W-1:0] b);
      byte_backlog.push_back(b);
      items_queued++;
   endtask

   task automatic push_sync();
      push_byte(rcfp_pkg::SYNC_OUTER);
      push_byte(rcfp_pkg::SYNC_INNER);
      push_byte(rcfp_pkg::SYNC_OUTER);
   endtask

   // A group is low byte, high byte and check; a broken group spoils the check byte.
   task automatic push_group(input logic [rcfp_pkg::VALUE_W-1:0] value, input bit good);
      logic [rcfp_pkg::BYTE_W-1:0] chk;
      chk = value[7:0] ^ value[15:8];
      if (!good) chk = chk ^ rcfp_pkg::BYTE_W'($urandom_range(1, 255));
      push_byte(value[7:0]);
      push_byte(value[15:8]);
      push_byte(chk);
   endtask

   task automatic write_csr(input logic [rcfp_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [rcfp_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic apply_settings(input logic [rcfp_pkg::BYTE_W-1:0] timeout,
                                 input logic signed [rcfp_pkg::VALUE_W-1:0] ceiling,
                                 input logic signed [rcfp_pkg::VALUE_W-1:0] floor_value);
      write_csr(rcfp_pkg::CSR_TIMEOUT, {8'h00, timeout});
      write_csr(rcfp_pkg::CSR_LIMIT_HIGH, ceiling);
      write_csr(rcfp_pkg::CSR_LIMIT_LOW, floor_value);
      settings_count++;
      @(posedge clock);
   endtask

   // Holds off the sender until every byte has been taken and every result seen.
   task automatic wait_idle();
      while (req_taken != items_queued || snapshot_due.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      @(posedge clock);
   endtask

   // Picks a value: mostly inside the limits, some on and just past them, the rest anywhere.
   function automatic logic [rcfp_pkg::VALUE_W-1:0] pick_value();
      int lo;
      int hi;
      int r;
      lo = int'(cfg_floor);
      hi = int'(cfg_ceiling);
      r  = $urandom_range(0, 9);
      if (r < 6 && lo <= hi) begin
         return rcfp_pkg::VALUE_W'(lo + int'($urandom_range(0, hi - lo)));
      end
      case (r)
         6: return rcfp_pkg::VALUE_W'(lo);
         7: return rcfp_pkg::VALUE_W'(hi + $urandom_range(0, 1));
         8: return rcfp_pkg::VALUE_W'(lo - 1);
         default: return rcfp_pkg::VALUE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Mostly well-formed frames with random content, mixed with broken groups and noise.
   task automatic random_stream(input int count);
      int start;
      int r;
      int burst;
      start = items_queued;
      while (items_queued - start < count) begin
         r = $urandom_range(0, 19);
         if (r < 4) begin
            push_sync();
         end else if (r < 15) begin
            push_group(pick_value(), 1'b1);
         end else if (r < 17) begin
            push_group(pick_value(), 1'b0);
         end else begin
            burst = (r == 19) ? $urandom_range(1, 24) : 1;
            repeat (burst) push_byte(rcfp_pkg::BYTE_W'($urandom_range(0, 255)));
         end
      end
   endtask

   // Stimulus sequence.
   initial begin
      logic signed [rcfp_pkg::VALUE_W-1:0] a;
      logic signed [rcfp_pkg::VALUE_W-1:0] b;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      settings_count = 1;
      src_idle_max   = 3;
      sink_idle_max  = 3;

      // Reset limits: both limits, one past the top, minus one, then a fifth group past the
      // last channel, a broken check and a sync that clears the flag.
      push_sync();
      push_group(16'sd500, 1'b1);
      push_group(-16'sd500, 1'b1);
      push_group(16'sd501, 1'b1);
      push_group(-16'sd1, 1'b1);
      push_group(16'h0000, 1'b1);
      push_group(16'h1234, 1'b0);
      push_sync();
      wait_idle();

      // Full range and the shortest timeout: extreme values, then a byte that both reaches
      // the timeout and completes a sync after a failed check.
      apply_settings(8'd4, 16'sh7FFF, -16'sh8000);
      push_sync();
      push_group(16'h8000, 1'b1);
      push_group(16'h7FFF, 1'b1);
      push_byte(8'h01);
      push_byte(rcfp_pkg::SYNC_OUTER);
      push_byte(rcfp_pkg::SYNC_INNER);
      push_byte(rcfp_pkg::SYNC_OUTER);
      wait_idle();

      // Random phases over a spread of register settings and idling patterns.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: apply_settings(8'd2, 16'sh7FFF, -16'sh8000);
            1: apply_settings(8'd255, 16'sd500, -16'sd500);
            2: apply_settings(8'd10, -16'sd100, 16'sd100);
            3: apply_settings(8'd0, 16'sh7FFF, -16'sh8000);
            default: begin
               a = rcfp_pkg::VALUE_W'($urandom_range(0, 65535));
               b = rcfp_pkg::VALUE_W'($urandom_range(0, 65535));
               if (a > b) apply_settings(rcfp_pkg::BYTE_W'($urandom_range(4, 40)), a, b);
               else apply_settings(rcfp_pkg::BYTE_W'($urandom_range(4, 40)), b, a);
            end
         endcase
         src_idle_max  = (phase % 3 == 1) ? 0 : 11;
         sink_idle_max = (phase % 3 == 2) ? 0 : 11;
         // Long receiver hold while the sender keeps offering bytes.
         if (phase == 4) hold_token++;
         random_stream(STREAM_BYTES);
         // A long run without sync or good group drives the counter to its top.
         if (phase == 1) begin
            push_group(16'h5555, 1'b0);
            repeat (270) push_byte(rcfp_pkg::BYTE_W'($urandom_range(1, 254)));
         end
         wait_idle();
      end

      if (snapshot_due.size() != 0) begin
         $error("%0d predicted results never arrived", snapshot_due.size());
         mismatches++;
      end
      $display("Fed %0d bytes under %0d register settings; %0d results checked, %0d mismatches.",
               items_queued, settings_count, rsp_taken, mismatches);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/rcfp_pkg.sv
src/rcfp_step.sv
src/rc_channel_frame_parser_core.sv
dv/tb.sv
